>>> hw/rtl/anhe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package anhe_pkg;

  localparam int unsigned HASH_KINDS         = 3;
  localparam int unsigned TABLE_GROUPS_DEF   = 5;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [31:0] SEED1_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED2_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] SEED2_INC  = 32'd3;

  localparam logic [21:0] LCG_SEED = 22'h100001;
  localparam logic [6:0]  LCG_MUL  = 7'd125;
  localparam logic [1:0]  LCG_INC  = 2'd3;
  localparam logic [21:0] LCG_MOD  = 22'h2AAAAB;

  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;
  localparam logic [7:0] CASE_DELTA  = 8'h20;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
  } name_word_t;

  typedef struct packed {
    logic [31:0] offset_hash;
    logic [31:0] hash_a;
    logic [31:0] hash_b;
  } hash_word_t;

  // one table write, fanned out to the per-kind memories
  typedef struct packed {
    logic [HASH_KINDS-1:0]      en;
    logic [HASH_KINDS-1:0][7:0] addr;
    logic [31:0]                data;
  } tbl_wr_t;

  typedef struct packed {
    logic [7:0]                  ch;
    logic                        last;
    logic [HASH_KINDS-1:0][31:0] words;
  } qent_t;

endpackage

`default_nettype wire

>>> hw/rtl/anhe_table_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module anhe_table_gen #(
  parameter int unsigned TABLE_GROUPS = anhe_pkg::TABLE_GROUPS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  output anhe_pkg::tbl_wr_t    wr,
  output logic                 table_ready
);
  import anhe_pkg::*;

  localparam int unsigned GW = (TABLE_GROUPS > 1) ? $clog2(TABLE_GROUPS) : 1;
  localparam logic [GW-1:0] GRP_LAST = GW'(TABLE_GROUPS - 1);

  typedef enum logic [3:0] {
    GEN_MUL  = 4'b0001,
    GEN_QUOT = 4'b0010,
    GEN_REM  = 4'b0100,
    GEN_DONE = 4'b1000
  } gen_state_t;

  gen_state_t  state;
  logic [21:0] seed;
  logic [28:0] prod_t;
  logic [7:0]  quot;
  logic [15:0] hi_half;
  logic        half;
  logic [7:0]  col;
  logic [GW-1:0] grp;

  logic [28:0] t_next;
  logic [30:0] t_times3;
  logic [29:0] q_times_mod;
  logic [29:0] diff;
  logic [29:0] rem_fix;
  logic [21:0] draw;

  // t = seed*125 + 3, then modulo 0x2AAAAB; 3*0x2AAAAB = 2^23 + 1 so
  // (3t >> 23) is the quotient or one too high
  always_comb begin
    t_next      = 29'(seed) * 29'(LCG_MUL) + 29'(LCG_INC);
    t_times3    = 31'(prod_t) + 31'({prod_t, 1'b0});
    q_times_mod = 30'(quot) * 30'(LCG_MOD);
    diff        = {1'b0, prod_t} - q_times_mod;
    rem_fix     = diff + 30'(LCG_MOD);
    draw        = diff[29] ? rem_fix[21:0] : diff[21:0];
  end

  // word (grp, col) sits at grp*256 + col; kind k reads k*255 + ch,
  // so memory k takes group k cols up to 255-k and the tail of group k-1
  always_comb begin
    logic [8:0] sum9;
    logic       base;
    base    = (state == GEN_REM) && half;
    wr.data = {hi_half, draw[15:0]};
    for (int k = 0; k < HASH_KINDS; k++) begin
      sum9       = {1'b0, col} + 9'(k);
      wr.addr[k] = sum9[7:0];
      wr.en[k]   = base && (((grp == GW'(k)) && !sum9[8]) ||
                            ((k > 0) && (grp == GW'(k - 1)) && sum9[8]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= GEN_MUL;
      seed        <= LCG_SEED;
      half        <= 1'b0;
      col         <= '0;
      grp         <= '0;
      table_ready <= 1'b0;
    end else begin
      unique case (state)
        GEN_MUL: begin
          prod_t <= t_next;
          state  <= GEN_QUOT;
        end
        GEN_QUOT: begin
          quot  <= t_times3[30:23];
          state <= GEN_REM;
        end
        GEN_REM: begin
          seed <= draw;
          if (!half) begin
            hi_half <= draw[15:0];
            half    <= 1'b1;
            state   <= GEN_MUL;
          end else begin
            half <= 1'b0;
            if (grp == GRP_LAST) begin
              grp <= '0;
              if (col == 8'hFF) begin
                state       <= GEN_DONE;
                table_ready <= 1'b1;
              end else begin
                col   <= col + 8'd1;
                state <= GEN_MUL;
              end
            end else begin
              grp   <= grp + GW'(1);
              state <= GEN_MUL;
            end
          end
        end
        GEN_DONE: begin
          state <= GEN_DONE;
        end
        default: begin
          state <= GEN_DONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/anhe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module anhe_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 name_valid,
  output logic                      name_stall,
  input  wire anhe_pkg::name_word_t name_word,
  input  wire anhe_pkg::tbl_wr_t    wr,
  input  wire logic                 table_ready,
  input  wire logic [$clog2(anhe_pkg::QUEUE_DEPTH):0] q_level,
  output logic                      push,
  output anhe_pkg::qent_t           push_ent
);
  import anhe_pkg::*;

  localparam int unsigned LW = $clog2(QUEUE_DEPTH) + 1;

  logic [31:0] crypt_mem [HASH_KINDS][256];
  logic [HASH_KINDS-1:0][31:0] rd_word;

  logic       accept;
  logic [7:0] ch;
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic [LW:0] committed;

  always_comb begin
    ch = name_word.name_byte;
    if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
      ch = ch - CASE_DELTA;
    end
  end

  // the word in the read stage already owns a queue slot
  assign committed  = {1'b0, q_level} + (LW + 1)'(s1_valid);
  assign name_stall = !table_ready || (committed >= (LW + 1)'(QUEUE_DEPTH));
  assign accept     = name_valid && !name_stall;

  // every kind reads at the folded byte itself
  always_ff @(posedge clk) begin
    for (int k = 0; k < HASH_KINDS; k++) begin
      if (wr.en[k]) begin
        crypt_mem[k][wr.addr[k]] <= wr.data;
      end
      rd_word[k] <= crypt_mem[k][ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_ch   <= ch;
      s1_last <= name_word.last_byte;
    end
  end

  assign push           = s1_valid;
  assign push_ent.ch    = s1_ch;
  assign push_ent.last  = s1_last;
  assign push_ent.words = rd_word;

endmodule

`default_nettype wire

>>> hw/rtl/anhe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module anhe_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire anhe_pkg::qent_t      push_ent,
  input  wire logic                 pop,
  output logic                      head_valid,
  output anhe_pkg::qent_t           head_ent,
  output logic [$clog2(anhe_pkg::QUEUE_DEPTH):0] level
);
  import anhe_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  qent_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;

  assign head_valid = (level != '0);
  assign head_ent   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + (PW + 1)'(1);
      end else if (pop && !push) begin
        level <= level - (PW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/anhe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module anhe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire anhe_pkg::qent_t      head_ent,
  output logic                      pop,
  output logic                      hash_valid,
  input  wire logic                 hash_stall,
  output anhe_pkg::hash_word_t      hash_word
);
  import anhe_pkg::*;

  logic [HASH_KINDS-1:0][31:0] seed1;
  logic [HASH_KINDS-1:0][31:0] seed2;
  logic [HASH_KINDS-1:0][31:0] seed1_next;
  logic [HASH_KINDS-1:0][31:0] seed2_next;
  logic out_free;

  always_comb begin
    for (int k = 0; k < HASH_KINDS; k++) begin
      seed1_next[k] = head_ent.words[k] ^ (seed1[k] + seed2[k]);
      seed2_next[k] = {24'd0, head_ent.ch} + seed1_next[k] + seed2[k] +
                      {seed2[k][26:0], 5'd0} + SEED2_INC;
    end
  end

  assign out_free = !hash_valid || !hash_stall;
  // a closing byte waits until the result register can take it
  assign pop      = head_valid && (!head_ent.last || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
      for (int k = 0; k < HASH_KINDS; k++) begin
        seed1[k] <= SEED1_INIT;
        seed2[k] <= SEED2_INIT;
      end
    end else begin
      if (pop && head_ent.last) begin
        hash_valid <= 1'b1;
      end else if (!hash_stall) begin
        hash_valid <= 1'b0;
      end
      if (pop) begin
        if (head_ent.last) begin
          hash_word.offset_hash <= seed1_next[0];
          hash_word.hash_a      <= seed1_next[1];
          hash_word.hash_b      <= seed1_next[2];
          for (int k = 0; k < HASH_KINDS; k++) begin
            seed1[k] <= SEED1_INIT;
            seed2[k] <= SEED2_INIT;
          end
        end else begin
          seed1 <= seed1_next;
          seed2 <= seed2_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/archive_name_hash_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Archive name hash engine: takes one name byte per word (last_byte marks the
// end of a name) and returns the offset, A and B hashes of the whole name as
// one result word after its last byte. After reset the crypt table is built by
// the on-chip generator, and name_stall stays high until it is done. From then on
// one byte is taken every cycle while the queue has room: the three table
// reads for a byte run in parallel, one memory per hash kind, and each seed
// pair is updated once per byte. hash_valid rises once the last byte has
// passed the table read at the taking edge, the queue write and then the
// result register update. While a result waits, bytes keep being taken until
// the next closing byte reaches the head of the four-entry queue and the
// queue fills up.
module archive_name_hash_engine_unit #(
  parameter int unsigned TABLE_GROUPS = anhe_pkg::TABLE_GROUPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 name_valid,
  output logic                      name_stall,
  input  wire anhe_pkg::name_word_t name_word,
  output logic                      hash_valid,
  input  wire logic                 hash_stall,
  output anhe_pkg::hash_word_t      hash_word
);
  import anhe_pkg::*;

  tbl_wr_t wr;
  logic    table_ready;
  logic    push;
  qent_t   push_ent;
  logic    pop;
  logic    head_valid;
  qent_t   head_ent;
  logic [$clog2(QUEUE_DEPTH):0] q_level;

  anhe_table_gen #(
    .TABLE_GROUPS(TABLE_GROUPS)
  ) u_table_gen (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .table_ready(table_ready)
  );

  anhe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .name_valid (name_valid),
    .name_stall (name_stall),
    .name_word  (name_word),
    .wr         (wr),
    .table_ready(table_ready),
    .q_level    (q_level),
    .push       (push),
    .push_ent   (push_ent)
  );

  anhe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .head_valid(head_valid),
    .head_ent  (head_ent),
    .level     (q_level)
  );

  anhe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_ent  (head_ent),
    .pop       (pop),
    .hash_valid(hash_valid),
    .hash_stall(hash_stall),
    .hash_word (hash_word)
  );

endmodule

`default_nettype wire

>>> test/tb_archive_name_hash_engine_unit.sv
`timescale 1ns / 1ps

module tb_archive_name_hash_engine_unit;
  import anhe_pkg::*;

  localparam int unsigned CRYPT_DEPTH = 256 * TABLE_GROUPS_DEF;
  localparam int unsigned KIND_STRIDE = 255;
  localparam int unsigned NAMES_PER_PHASE_BYTES = 257;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       name_valid = 1'b0;
  logic       name_stall;
  name_word_t name_word = '0;
  logic       hash_valid;
  logic       hash_stall = 1'b0;
  hash_word_t hash_word;

  logic [31:0] crypt_words [CRYPT_DEPTH];
  logic [31:0] run_seed1 [HASH_KINDS];
  logic [31:0] run_seed2 [HASH_KINDS];
  hash_word_t  expected_hashes [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  archive_name_hash_engine_unit dut (
    .clk        (clk),
    .rst        (rst),
    .name_valid (name_valid),
    .name_stall (name_stall),
    .name_word  (name_word),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_word  (hash_word)
  );

  always #5 clk = ~clk;

  // same generator the engine runs after reset, column-major over the groups
  function automatic void build_crypt_words();
    logic [63:0] lcg;
    logic [15:0] hi;
    logic [15:0] lo;
    lcg = 64'h0010_0001;
    for (int col = 0; col < 256; col++) begin
      for (int grp = 0; grp < int'(TABLE_GROUPS_DEF); grp++) begin
        lcg = (lcg * 125 + 3) % 64'h2AAAAB;
        hi = lcg[15:0];
        lcg = (lcg * 125 + 3) % 64'h2AAAAB;
        lo = lcg[15:0];
        crypt_words[grp * 256 + col] = {hi, lo};
      end
    end
  endfunction

  function automatic void restart_name();
    for (int k = 0; k < int'(HASH_KINDS); k++) begin
      run_seed1[k] = SEED1_INIT;
      run_seed2[k] = SEED2_INIT;
    end
  endfunction

  function automatic void absorb_name_byte(name_word_t w);
    logic [31:0] ch;
    logic [31:0] idx;
    logic [31:0] s1;
    logic [31:0] s2;
    ch = {24'd0, w.name_byte};
    if (w.name_byte >= LOWER_FIRST && w.name_byte <= LOWER_LAST) begin
      ch = ch - {24'd0, CASE_DELTA};
    end
    for (int k = 0; k < int'(HASH_KINDS); k++) begin
      idx = k * KIND_STRIDE + ch;
      s1 = run_seed1[k];
      s2 = run_seed2[k];
      s1 = ((idx < CRYPT_DEPTH) ? crypt_words[idx] : 32'd0) ^ (s1 + s2);
      s2 = ch + s1 + s2 + (s2 << 5) + 32'd3;
      run_seed1[k] = s1;
      run_seed2[k] = s2;
    end
    if (w.last_byte) begin
      expected_hashes.push_back('{offset_hash: run_seed1[0], hash_a: run_seed1[1],
                                  hash_b: run_seed1[2]});
      restart_name();
    end
  endfunction

  function automatic void check_hash_word(hash_word_t got);
    hash_word_t want;
    if (expected_hashes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected hash word: offset %h a %h b %h",
                 got.offset_hash, got.hash_a, got.hash_b);
      end
    end else begin
      want = expected_hashes.pop_front();
      if (got.offset_hash !== want.offset_hash || got.hash_a !== want.hash_a ||
          got.hash_b !== want.hash_b) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("hash mismatch: expected offset %h a %h b %h, got offset %h a %h b %h",
                   want.offset_hash, want.hash_a, want.hash_b,
                   got.offset_hash, got.hash_a, got.hash_b);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (name_valid && !name_stall) begin
        absorb_name_byte(name_word);
      end
      if (hash_valid && !hash_stall) begin
        check_hash_word(hash_word);
      end
    end
  end

  always @(negedge clk) begin
    hash_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // returns at a falling edge with valid still high so back-to-back words stay valid
  task automatic send_name_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      name_valid <= 1'b0;
      @(negedge clk);
    end
    name_valid <= 1'b1;
    name_word <= '{name_byte: b, last_byte: fin};
    @(posedge clk);
    while (name_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_name(input logic [7:0] chars [$]);
    for (int i = 0; i < chars.size(); i++) begin
      send_name_byte(chars[i], i == chars.size() - 1);
    end
  endtask

  function automatic logic [7:0] pick_name_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return 8'($urandom_range(8'h61, 8'h7A));
    if (roll < 55) return 8'($urandom_range(8'h41, 8'h5A));
    if (roll < 80) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_names(input int byte_budget);
    int sent;
    int len;
    logic [7:0] chars [$];
    sent = 0;
    while (sent < byte_budget) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      chars.delete();
      for (int i = 0; i < len; i++) chars.push_back(pick_name_char());
      send_name(chars);
      sent += len;
    end
  endtask

  task automatic wait_for_drain();
    while (expected_hashes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    send_random_names(NAMES_PER_PHASE_BYTES);
    name_valid <= 1'b0;
    wait_for_drain();
  endtask

  task automatic test_directed_names();
    send_idle_pct = 0;
    stall_pct = 0;
    // extremes of the byte as one-byte names
    send_name('{8'h00});
    send_name('{8'hFF});
    // case folding and its neighbors
    send_name('{8'h61});
    send_name('{8'h41});
    send_name('{8'h7A});
    send_name('{8'h5A});
    send_name('{8'h60});
    send_name('{8'h7B});
    send_name('{8'h40});
    send_name('{8'h5B});
    // zero byte inside a name does not end it
    send_name('{8'h78, 8'h00, 8'h79});
    // high bytes used unchanged
    send_name('{8'h80, 8'hFE, 8'hAA, 8'h55});
    send_name('{8'h41, 8'h62, 8'h2E, 8'h63});
    name_valid <= 1'b0;
    wait_for_drain();
  endtask

  task automatic test_streaming_no_idle();
    run_phase(0, 0);
  endtask

  task automatic test_sender_gaps();
    run_phase(73, 0);
  endtask

  task automatic test_receiver_backpressure();
    run_phase(0, 73);
  endtask

  task automatic test_both_sides_idle();
    run_phase(31, 31);
  endtask

  initial begin
    build_crypt_words();
    restart_name();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_names();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_backpressure();
    test_both_sides_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // table fill after reset is the longest part of the run, the rest is far shorter
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/anhe_pkg.sv
hw/rtl/anhe_table_gen.sv
hw/rtl/anhe_front.sv
hw/rtl/anhe_queue.sv
hw/rtl/anhe_back.sv
hw/rtl/archive_name_hash_engine_unit.sv
test/tb_archive_name_hash_engine_unit.sv
